/* src/bbc_pkg.sv */
// Shared constants, types and command/status structs of the blob centroid unit.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    // Default size limits of the frame counters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Fixed field widths
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_ADDR_W  = 1;
    localparam int OUT_W       = 10;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - 2 * OUT_W;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic pix_en;     // pixel beat taken this cycle
        logic div_start;  // last pixel of frame: snapshot sums into divider
        logic div_step;   // one quotient bit per cycle
        logic out_load;   // move quotients into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_last; // current position is the last pixel of the frame
        logic div_last;   // divider is on its final step
        logic out_free;   // output register can take a result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

/* src/binary_blob_centroid_unit.sv */
// Top level of the binary blob centroid unit.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 8-bit pixel per beat in raster order and, after the last pixel
// of each frame, returns one beat with a found flag and the truncated mean
// column and row of all nonzero pixels (both zero when none was set). Within
// a frame a pixel is taken every clock. After the last pixel the input
// pauses for the divider, one quotient bit per cycle, then for the load of
// the result register, which waits until the output register is free.
// Writing either size register restarts the frame; a size of zero counts
// as one and a size above the limit is clipped to it.
module binary_blob_centroid_unit #(
    parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [bbc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [bbc_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bbc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] pixel_value
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bbc_pkg::OUT_TDATA_W-1:0]      m_tdata   // [0] found, [10:1] centroid_x,
                                                           // [20:11] centroid_y
);
    import bbc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bbc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

/* src/bbc_ctrl.sv */
// Sequencer of the blob centroid unit: pixel accumulation, division, result load.
`timescale 1ns / 1ps
`default_nettype none

module bbc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire bbc_pkg::dp_status_t status,
    output bbc_pkg::ctrl_cmd_t      cmd
);
    import bbc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_tvalid && status.frame_last) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_ACCUM: begin
                s_tready      = 1'b1;
                cmd.pix_en    = s_tvalid;
                cmd.div_start = s_tvalid && status.frame_last;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_LOAD: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A frame ends only on a taken pixel, and the divider runs right after.
    a_start_enters_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> state_reg == ST_DIVIDE)
        else $error("divider start did not enter divide state");

    // No pixel is taken while a division or a result load is pending.
    a_no_pixel_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE || state_reg == ST_LOAD) |-> !cmd.pix_en)
        else $error("pixel taken while division pending");

    // Result load happens once per division.
    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> !cmd.out_load)
        else $error("result loaded twice");
`endif

endmodule

`default_nettype wire

/* src/bbc_datapath.sv */
// Position counters, coordinate sums, restoring divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module bbc_datapath #(
    parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [bbc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [bbc_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire logic [bbc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bbc_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire bbc_pkg::ctrl_cmd_t                  cmd,
    output bbc_pkg::dp_status_t                      status
);
    import bbc_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DQ_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int SUM_W  = DQ_W + CNT_W;
    localparam int STEP_W = (DQ_W > 1) ? $clog2(DQ_W) : 1;
    localparam int WLIM_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HLIM_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    // Configuration
    logic [CFG_W-1:0] fw_reg, fw_next;
    logic [CFG_W-1:0] fh_reg, fh_next;
    logic             cfg_hit;

    // Frame accumulation
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0] xsum_reg, xsum_next, xsum_add;
    logic [SUM_W-1:0] ysum_reg, ysum_next, ysum_add;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_add;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             pix_set;
    logic             col_last;

    // Divider
    logic [SUM_W-1:0]  remx_reg, remx_next;
    logic [SUM_W-1:0]  remy_reg, remy_next;
    logic [SUM_W-1:0]  den_reg, den_next;
    logic [DQ_W-1:0]   qx_reg, qx_next;
    logic [DQ_W-1:0]   qy_reg, qy_next;
    logic              nz_reg, nz_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              x_ge, y_ge;

    // Output register
    logic                   mvalid_reg, mvalid_next;
    logic [OUT_TDATA_W-1:0] mdata_reg, mdata_next;
    logic [OUT_W-1:0]       cx, cy;

    // Frame size, zero taken as one and oversize clipped to the limit
    always_comb begin
        if (fw_reg == '0) begin
            last_col = '0;
        end else if (WLIM_W'(fw_reg) > WLIM_W'(MAX_WIDTH)) begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            last_col = COL_W'(fw_reg - 1'b1);
        end
        if (fh_reg == '0) begin
            last_row = '0;
        end else if (HLIM_W'(fh_reg) > HLIM_W'(MAX_HEIGHT)) begin
            last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            last_row = ROW_W'(fh_reg - 1'b1);
        end
    end

    assign cfg_hit  = cfg_we && (cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT);
    assign pix_set  = s_tdata[PIX_W-1:0] != '0;
    assign col_last = col_reg == last_col;

    assign status.frame_last = col_last && (row_reg == last_row);
    assign status.div_last   = step_reg == '0;
    assign status.out_free   = !mvalid_reg || m_tready;

    always_comb begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_we && cfg_addr == REG_FRAME_WIDTH) begin
            fw_next = cfg_wdata;
        end
        if (cfg_we && cfg_addr == REG_FRAME_HEIGHT) begin
            fh_next = cfg_wdata;
        end
    end

    // Sums including the current pixel
    always_comb begin
        xsum_add = xsum_reg;
        ysum_add = ysum_reg;
        cnt_add  = cnt_reg;
        if (pix_set) begin
            xsum_add = xsum_reg + SUM_W'(col_reg);
            ysum_add = ysum_reg + SUM_W'(row_reg);
            cnt_add  = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        xsum_next = xsum_reg;
        ysum_next = ysum_reg;
        cnt_next  = cnt_reg;
        priority if (cfg_hit || cmd.div_start) begin
            col_next  = '0;
            row_next  = '0;
            xsum_next = '0;
            ysum_next = '0;
            cnt_next  = '0;
        end else if (cmd.pix_en) begin
            xsum_next = xsum_add;
            ysum_next = ysum_add;
            cnt_next  = cnt_add;
            if (col_last) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Restoring division; the quotient fits DQ_W bits, so the divisor
    // starts shifted up by DQ_W-1 and walks down one bit per step.
    assign x_ge = remx_reg >= den_reg;
    assign y_ge = remy_reg >= den_reg;

    always_comb begin
        remx_next = remx_reg;
        remy_next = remy_reg;
        den_next  = den_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        nz_next   = nz_reg;
        step_next = step_reg;
        priority if (cmd.div_start) begin
            remx_next = xsum_add;
            remy_next = ysum_add;
            den_next  = SUM_W'(cnt_add) << (DQ_W - 1);
            qx_next   = '0;
            qy_next   = '0;
            nz_next   = cnt_add != '0;
            step_next = STEP_W'(DQ_W - 1);
        end else if (cmd.div_step) begin
            if (x_ge) begin
                remx_next = remx_reg - den_reg;
            end
            if (y_ge) begin
                remy_next = remy_reg - den_reg;
            end
            qx_next   = (qx_reg << 1) | DQ_W'(x_ge);
            qy_next   = (qy_reg << 1) | DQ_W'(y_ge);
            den_next  = den_reg >> 1;
            step_next = step_reg - 1'b1;
        end
    end

    assign cx = nz_reg ? OUT_W'(qx_reg) : '0;
    assign cy = nz_reg ? OUT_W'(qy_reg) : '0;

    always_comb begin
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
            mdata_next  = {{OUT_PAD_W{1'b0}}, cy, cx, nz_reg};
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg     <= RST_FRAME_WIDTH;
            fh_reg     <= RST_FRAME_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
            xsum_reg   <= '0;
            ysum_reg   <= '0;
            cnt_reg    <= '0;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            fw_reg     <= fw_next;
            fh_reg     <= fh_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            xsum_reg   <= xsum_next;
            ysum_reg   <= ysum_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        remx_reg  <= remx_next;
        remy_reg  <= remy_next;
        den_reg   <= den_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        nz_reg    <= nz_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

`ifndef ASSERT_OFF
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= last_col)
        else $error("column counter past end of row");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= last_row)
        else $error("row counter past end of frame");

    a_load_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_tready))
        else $error("result loaded over an untaken beat");

    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !mdata_reg[0]) |-> (mdata_reg[2*OUT_W:1] == '0))
        else $error("empty frame with nonzero centroid");
`endif

endmodule

`default_nettype wire

/* tb/centroid_checker.sv */
// Checker for the blob centroid unit: tracks frames on the pixel channel and compares results.
`timescale 1ns / 1ps

module centroid_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [bbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bbc_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [bbc_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] pixel_value
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [bbc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [0] found, [10:1] centroid_x,
                                                           // [20:11] centroid_y
    output int                                  mismatches,
    output int                                  pending
);
    import bbc_pkg::*;

    // packed so that found lands in bit 0, as on m_tdata
    typedef struct packed {
        logic [OUT_W-1:0] cy;
        logic [OUT_W-1:0] cx;
        logic             found;
    } centroid_t;

    centroid_t        centroid_q[$];
    int               fail_count = 0;
    int               queued     = 0;

    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] height_cfg;
    logic [9:0]       col_pos;
    logic [9:0]       row_pos;
    logic [39:0]      col_sum;
    logic [39:0]      row_sum;
    logic [20:0]      px_count;

    assign mismatches = fail_count;
    assign pending    = queued;

    function automatic int frame_dim(logic [CFG_W-1:0] v, int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    task clear_frame();
        col_pos  = '0;
        row_pos  = '0;
        col_sum  = '0;
        row_sum  = '0;
        px_count = '0;
    endtask

    task report(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Adds one pixel at the current position; queues the centroid at frame end.
    task accumulate_pixel(input logic [PIX_W-1:0] pix);
        centroid_t   c;
        logic [39:0] qx;
        logic [39:0] qy;
        if (pix != '0) begin
            col_sum  = col_sum + col_pos;
            row_sum  = row_sum + row_pos;
            px_count = px_count + 1'b1;
        end
        if (int'(col_pos) + 1 >= frame_dim(width_cfg, DEF_MAX_WIDTH)) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= frame_dim(height_cfg, DEF_MAX_HEIGHT)) begin
                c = '0;
                if (px_count != '0) begin
                    qx      = col_sum / px_count;
                    qy      = row_sum / px_count;
                    c.found = 1'b1;
                    c.cx    = qx[OUT_W-1:0];
                    c.cy    = qy[OUT_W-1:0];
                end
                centroid_q.push_back(c);
                clear_frame();
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        centroid_t got;
        centroid_t want;
        if (!aresetn) begin
            width_cfg  = RST_FRAME_WIDTH;
            height_cfg = RST_FRAME_HEIGHT;
            clear_frame();
            centroid_q.delete();
        end else begin
            // results compared before this edge's pixel: a result never
            // leaves in the same cycle as its frame's last pixel
            if (m_tvalid && m_tready) begin
                got = centroid_t'(m_tdata[2*OUT_W:0]);
                if (centroid_q.size() == 0) begin
                    report("result beat with no frame completed");
                end else begin
                    want = centroid_q.pop_front();
                    if (got.found !== want.found)
                        report($sformatf("found: expected %0d, got %0d", want.found, got.found));
                    if (got.cx !== want.cx)
                        report($sformatf("centroid_x: expected %0d, got %0d", want.cx, got.cx));
                    if (got.cy !== want.cy)
                        report($sformatf("centroid_y: expected %0d, got %0d", want.cy, got.cy));
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH: begin
                        width_cfg = cfg_wdata;
                        clear_frame();
                    end
                    REG_FRAME_HEIGHT: begin
                        height_cfg = cfg_wdata;
                        clear_frame();
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                accumulate_pixel(s_tdata[PIX_W-1:0]);
        end
        queued = centroid_q.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the blob centroid testbench: clock, reset, pixel and result traffic, verdict.
`timescale 1ns / 1ps

module testbench;
    import bbc_pkg::*;

    localparam int RANDOM_PIXELS = 700;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;

    typedef enum {
        FILL_EMPTY,
        FILL_SOLID,
        FILL_SPARSE,
        FILL_NOISE,
        FILL_LAST_ONLY,
        FILL_FIRST_ONLY
    } fill_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]        cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    int                      mismatches;
    int                      pending;
    bit                      no_idle     = 1'b0;
    int                      pixels_sent = 0;
    int                      idle_cycles = 0;

    binary_blob_centroid_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    centroid_checker u_centroid_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(fill_t fill, int idx, int total);
        case (fill)
            FILL_EMPTY:      return '0;
            FILL_SOLID:      return PIX_W'($urandom_range(1, 255));
            FILL_SPARSE:     return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(1, 255)) : '0;
            FILL_NOISE:      return ($urandom_range(0, 1) == 0) ? PIX_W'($urandom) : '0;
            FILL_LAST_ONLY:  return (idx == total - 1) ? PIX_W'($urandom_range(1, 255)) : '0;
            FILL_FIRST_ONLY: return (idx == 0) ? PIX_W'($urandom_range(1, 255)) : '0;
            default:         return '0;
        endcase
    endfunction

    task send_pixel(input logic [PIX_W-1:0] pix);
        repeat (draw_gap()) @(negedge aclk) s_tvalid <= 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    // both writes restart the frame; only issued with the input idle
    task set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_addr  <= REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h, input int frames,
                   input fill_t fill, input bit vary);
        int    w_eff;
        int    h_eff;
        int    total;
        fill_t f;
        set_frame_size(w, h);
        w_eff = (w == '0) ? 1 : ((int'(w) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w));
        h_eff = (h == '0) ? 1 : ((int'(h) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(h));
        total = w_eff * h_eff;
        repeat (frames) begin
            f = vary ? fill_t'($urandom_range(0, int'(FILL_FIRST_ONLY))) : fill;
            for (int i = 0; i < total; i++)
                send_pixel(pick_pixel(f, i, total));
        end
        drain();
    endtask

    // result side: holds off a pending beat for a drawn number of cycles
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                @(negedge aclk) m_tready <= no_idle;
            end else if (m_tvalid) begin
                repeat (draw_gap()) @(posedge aclk);
                @(negedge aclk) m_tready <= 1'b1;
            end else if (no_idle && !m_tready) begin
                @(negedge aclk) m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [PIX_W-1:0] single_px[7];
        logic [PIX_W-1:0] small_frame[6];
        int               random_start;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        single_px   = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA};
        small_frame = '{8'h00, 8'h00, 8'h05, 8'h00, 8'h09, 8'hC8};

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // zero sizes count as one: every pixel is a frame of its own
        set_frame_size('0, '0);
        foreach (single_px[i])
            send_pixel(single_px[i]);
        drain();

        // 3x2 frame with a partial blob, then an empty one
        set_frame_size(11'd3, 11'd2);
        foreach (small_frame[i])
            send_pixel(small_frame[i]);
        repeat (6) send_pixel('0);
        drain();

        // widest row (oversized width clips), blob in the far corner
        run_phase(11'd2047, 11'd1, 1, FILL_LAST_ONLY, 1'b0);

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            w = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 40))
                                            : CFG_W'($urandom_range(1, 12));
            h = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 24))
                                            : CFG_W'($urandom_range(1, 8));
            run_phase(w, h, $urandom_range(1, 4), FILL_NOISE, 1'b1);
        end

        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/bbc_pkg.sv
src/bbc_ctrl.sv
src/bbc_datapath.sv
src/binary_blob_centroid_unit.sv
tb/centroid_checker.sv
tb/testbench.sv
